// ----- rtl/assert_macros.svh -----
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define BBRN_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define BBRN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bbrn_pkg.sv -----
// shared constants and types of the requisite-node block
package bbrn_pkg;

    // fixed field widths
    localparam int MASK_W  = 64;
    localparam int INDEX_W = 6;
    localparam int COUNT_W = 7;

    // default graph size and register reset value
    localparam int MAX_NODES_DEF = 64;
    localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 7'd64;

    // action codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_RUN  = 1'b1;

    // control from the sequencer to the row evaluator
    typedef struct packed {
        logic enable;
        logic anc_phase;
    } sweep_ctl_t;

endpackage

// ----- rtl/bbrn_ifs.sv -----
// valid/ready channel interfaces of the requisite-node block
interface bbrn_in_if;
    logic                             valid;
    logic                             ready;
    logic                             action;
    logic [bbrn_pkg::INDEX_W-1:0]     node_index;
    logic [bbrn_pkg::MASK_W-1:0]      parent_mask;
    logic                             is_query;
    logic                             is_hard;
    logic                             is_soft;

    modport source (
        output valid, action, node_index, parent_mask, is_query, is_hard, is_soft,
        input  ready
    );
    modport sink (
        input  valid, action, node_index, parent_mask, is_query, is_hard, is_soft,
        output ready
    );
endinterface

interface bbrn_out_if;
    logic                             valid;
    logic                             ready;
    logic [bbrn_pkg::MASK_W-1:0]      requisite_mask;

    modport source (
        output valid, requisite_mask,
        input  ready
    );
    modport sink (
        input  valid, requisite_mask,
        output ready
    );
endinterface

// ----- rtl/bbrn_row_mem.sv -----
// parent-row memory: one write port, one registered read port
module bbrn_row_mem #(
    parameter int N  = bbrn_pkg::MAX_NODES_DEF,
    parameter int AW = $clog2(N)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [N-1:0]  wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [N-1:0]  rdata
);

    logic [N-1:0] rows_mem [N];
    logic [N-1:0] rdata_reg;

    // write on load
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            rows_mem[waddr] <= wdata;
        end
    end

    // registered read during sweeps
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= rows_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/bbrn_row_eval.sv -----
// row evaluator: applies the closure or ball rules of one parent row
module bbrn_row_eval #(
    parameter int N  = bbrn_pkg::MAX_NODES_DEF,
    parameter int AW = $clog2(N)
) (
    input  bbrn_pkg::sweep_ctl_t ctl,
    input  logic [AW-1:0]        row_idx,
    input  logic [N-1:0]         row,
    input  logic [N-1:0]         active,
    input  logic [N-1:0]         hard,
    input  logic [N-1:0]         anc_in,
    input  logic [N-1:0]         c_in,
    input  logic [N-1:0]         p_in,
    output logic [N-1:0]         anc_out,
    output logic [N-1:0]         c_out,
    output logic [N-1:0]         p_out,
    output logic                 changed
);

    logic [N-1:0] row_act;
    logic [N-1:0] passing;
    logic         push_up;
    logic         push_down;

    assign row_act = row & active;

    // nodes that forward the ball to their children
    assign passing   = (c_in | p_in) & ~hard;
    assign push_up   = c_in[row_idx] | (p_in[row_idx] & anc_in[row_idx]);
    assign push_down = |(row_act & passing);

    // set updates for the current row
    always_comb
    begin
        anc_out = anc_in;
        c_out   = c_in;
        p_out   = p_in;
        if (ctl.enable)
        begin
            if (ctl.anc_phase)
            begin
                if (anc_in[row_idx])
                begin
                    anc_out = anc_in | row_act;
                end
            end
            else
            begin
                if (push_up)
                begin
                    c_out = c_in | row_act;
                end
                if (push_down)
                begin
                    p_out[row_idx] = 1'b1;
                end
            end
        end
    end

    assign changed = (anc_out != anc_in) || (c_out != c_in) || (p_out != p_in);

endmodule

// ----- rtl/bayes_ball_requisite_nodes.sv -----
// requisite-node analysis: a load writes one parent row and its flags; a run sweeps
// the parent rows pass after pass through the one row memory port
// and the shared row evaluator; closure passes repeat until the ancestor set
// is stable, then ball passes until the reached sets are stable, with at least
// one pass of each; a count of zero skips the sweeps and goes to the result
// reset clears flags, sets and the output stage and sets node_count to 64
module bayes_ball_requisite_nodes #(
    parameter int MAX_NODES = bbrn_pkg::MAX_NODES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bbrn_pkg::COUNT_W-1:0]   cfg_wdata,
    bbrn_in_if.sink                        item,
    bbrn_out_if.source                     result
);

    localparam int N  = MAX_NODES;
    localparam int AW = $clog2(N);
    localparam int CW = $clog2(N + 1);
    localparam int MW = bbrn_pkg::MASK_W;
    localparam int KW = bbrn_pkg::COUNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ANC,
        S_RUN,
        S_DONE
    } state_t;

    state_t               state_reg;
    logic [KW-1:0]        node_count_reg;
    logic [CW-1:0]        count_reg;
    logic [N-1:0]         active_reg;
    logic [N-1:0]         query_reg;
    logic [N-1:0]         hard_reg;
    logic [N-1:0]         soft_reg;
    logic [N-1:0]         anc_reg;
    logic [N-1:0]         from_child_reg;
    logic [N-1:0]         from_parent_reg;
    logic [CW-1:0]        issue_cnt_reg;
    logic                 rd_valid_reg;
    logic [AW-1:0]        rd_idx_reg;
    logic                 changed_reg;
    logic                 out_valid_reg;
    logic [MW-1:0]        out_mask_reg;

    logic                 in_fire;
    logic                 load_fire;
    logic                 run_fire;
    logic                 load_ok;
    logic [AW-1:0]        load_idx;
    logic [N-1:0]         load_bit;
    logic [CW-1:0]        count_next;
    logic [N:0]           active_wide;
    logic [N-1:0]         active_next;
    logic                 sweeping;
    logic                 issuing;
    logic                 pass_end;
    logic                 pass_changed;
    logic [N-1:0]         hard_act;
    logic [N-1:0]         row_data;
    bbrn_pkg::sweep_ctl_t ev_ctl;
    logic [N-1:0]         ev_anc;
    logic [N-1:0]         ev_c;
    logic [N-1:0]         ev_p;
    logic                 ev_chg;

    // handshake
    assign item.ready   = (state_reg == S_IDLE);
    assign in_fire      = item.valid && item.ready;
    assign load_fire    = in_fire && (item.action == bbrn_pkg::ACT_LOAD);
    assign run_fire     = in_fire && (item.action == bbrn_pkg::ACT_RUN);
    assign result.valid = out_valid_reg;
    assign result.requisite_mask = out_mask_reg;

    // load addressing, indices beyond the graph are dropped
    assign load_ok  = ({1'b0, item.node_index} < 7'(N));
    assign load_idx = item.node_index[AW-1:0];
    assign load_bit = N'(1) << load_idx;

    // nodes in use and their mask
    assign count_next  = (node_count_reg > KW'(N)) ? CW'(N) : CW'(node_count_reg);
    assign active_wide = ((N + 1)'(1) << count_next) - (N + 1)'(1);
    assign active_next = active_wide[N-1:0];
    assign hard_act    = hard_reg & active_reg;

    // row sweep control
    assign sweeping     = (state_reg == S_ANC) || (state_reg == S_RUN);
    assign issuing      = sweeping && (issue_cnt_reg < count_reg);
    assign pass_end     = rd_valid_reg && (CW'(rd_idx_reg) == count_reg - CW'(1));
    assign pass_changed = changed_reg || ev_chg;

    assign ev_ctl.enable    = sweeping && rd_valid_reg;
    assign ev_ctl.anc_phase = (state_reg == S_ANC);

    bbrn_row_mem #(
        .N  (N),
        .AW (AW)
    ) u_row_mem (
        .clk   (clk),
        .we    (load_fire && load_ok),
        .waddr (load_idx),
        .wdata (item.parent_mask[N-1:0]),
        .re    (issuing),
        .raddr (issue_cnt_reg[AW-1:0]),
        .rdata (row_data)
    );

    bbrn_row_eval #(
        .N  (N),
        .AW (AW)
    ) u_row_eval (
        .ctl     (ev_ctl),
        .row_idx (rd_idx_reg),
        .row     (row_data),
        .active  (active_reg),
        .hard    (hard_act),
        .anc_in  (anc_reg),
        .c_in    (from_child_reg),
        .p_in    (from_parent_reg),
        .anc_out (ev_anc),
        .c_out   (ev_c),
        .p_out   (ev_p),
        .changed (ev_chg)
    );

    // sequencer, sets and output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            node_count_reg  <= bbrn_pkg::NODE_COUNT_RESET;
            count_reg       <= '0;
            active_reg      <= '0;
            query_reg       <= '0;
            hard_reg        <= '0;
            soft_reg        <= '0;
            anc_reg         <= '0;
            from_child_reg  <= '0;
            from_parent_reg <= '0;
            issue_cnt_reg   <= '0;
            rd_valid_reg    <= 1'b0;
            rd_idx_reg      <= '0;
            changed_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_mask_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end

            if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (load_fire && load_ok)
                    begin
                        query_reg <= item.is_query ? (query_reg | load_bit)
                                                   : (query_reg & ~load_bit);
                        hard_reg  <= item.is_hard ? (hard_reg | load_bit)
                                                  : (hard_reg & ~load_bit);
                        soft_reg  <= item.is_soft ? (soft_reg | load_bit)
                                                  : (soft_reg & ~load_bit);
                    end
                    if (run_fire)
                    begin
                        count_reg       <= count_next;
                        active_reg      <= active_next;
                        anc_reg         <= (hard_reg | soft_reg) & active_next;
                        from_child_reg  <= query_reg & active_next;
                        from_parent_reg <= '0;
                        issue_cnt_reg   <= '0;
                        rd_valid_reg    <= 1'b0;
                        changed_reg     <= 1'b0;
                        state_reg       <= (count_next == '0) ? S_DONE : S_ANC;
                    end
                end

                S_ANC, S_RUN:
                begin
                    if (issuing)
                    begin
                        issue_cnt_reg <= issue_cnt_reg + CW'(1);
                    end
                    rd_valid_reg <= issuing;
                    rd_idx_reg   <= issue_cnt_reg[AW-1:0];
                    if (rd_valid_reg)
                    begin
                        anc_reg         <= ev_anc;
                        from_child_reg  <= ev_c;
                        from_parent_reg <= ev_p;
                        changed_reg     <= pass_changed;
                    end
                    // pass over: repeat while anything moved
                    if (pass_end)
                    begin
                        issue_cnt_reg <= '0;
                        changed_reg   <= 1'b0;
                        if (!pass_changed)
                        begin
                            state_reg <= (state_reg == S_ANC) ? S_RUN : S_DONE;
                        end
                    end
                end

                S_DONE:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_mask_reg  <= MW'((from_child_reg | from_parent_reg) & ~hard_act);
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/bbrn_checker.sv -----
// port-level checker of the requisite-node block and its bind
`include "assert_macros.svh"

module bbrn_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          in_action,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [bbrn_pkg::MASK_W-1:0]   out_mask
);

    // a run transaction makes the block busy
    `BBRN_ASSERT_NEXT(a_run_busy, clk, rst_n, in_valid && in_ready && in_action == bbrn_pkg::ACT_RUN, !in_ready, "input ready right after a run transaction")

    // a load never produces a result
    `BBRN_ASSERT_NEXT(a_load_silent, clk, rst_n, in_valid && in_ready && in_action == bbrn_pkg::ACT_LOAD && !out_valid, !out_valid, "result after a load transaction")

    // a result appears only at the end of a busy period
    `BBRN_ASSERT_NOW(a_result_from_busy, clk, rst_n, $rose(out_valid), !$past(in_ready), "result rose while the block was idle")

    // a waiting result holds
    `BBRN_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_mask), "result dropped or changed while stalled")

endmodule

bind bayes_ball_requisite_nodes bbrn_checker u_bbrn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .in_action (item.action),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_mask  (result.requisite_mask)
);
